// ===== rtl/core/octree_voxel_point_counter_assert.svh =====
// Assertion macros shared by the octree voxel point counter RTL.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef OCTREE_VOXEL_POINT_COUNTER_ASSERT_SVH
`define OCTREE_VOXEL_POINT_COUNTER_ASSERT_SVH

// Whenever cond holds, expr must hold in the same cycle.
`define OVPC_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
   else $error(msg);

// Whenever cond holds, expr must hold in the following cycle.
`define OVPC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
   else $error(msg);

`endif

// ===== rtl/core/ovpc_pkg.sv =====
// Shared types, constants and region-code helpers for the octree voxel point counter.
// Used by ovpc_walker, octree_voxel_point_counter and the testbench; depends on nothing.
package ovpc_pkg;

   localparam int TREE_DEPTH_DEFAULT = 4;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int COORD_W    = 16;
   localparam int SELECT_W   = 12;
   localparam int INDEX_W    = 12;
   localparam int OCOUNT_W   = 16;
   localparam int REG_W      = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CENTER_Z  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_X  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_Y  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_Z  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MIN_LEAF  = 3'd6;

   localparam logic [REG_W-1:0] EXTENT_RESET   = 16'd4096;
   localparam logic [REG_W-1:0] MIN_LEAF_RESET = 16'd1;

   // Item kinds carried on the request tuser.
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [REG_W-1:0]          extent_x;
      logic [REG_W-1:0]          extent_y;
      logic [REG_W-1:0]          extent_z;
   } geometry_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } coord_type;

   // Region code from the three "below centre" flags.
   function automatic logic [2:0] region_code(input logic neg_x, input logic neg_y,
                                              input logic neg_z);
      region_code = {neg_y, neg_x, neg_z ^ neg_x};
   endfunction

   // Inverse of region_code: bit 0 is x below, bit 1 y below, bit 2 z below.
   function automatic logic [2:0] region_neg(input logic [2:0] code);
      region_neg = {code[0] ^ code[1], code[2], code[1]};
   endfunction

endpackage

// ===== rtl/core/ovpc_walker.sv =====
// Iterative octree descent, one level per cycle, for the voxel point counter.
// Depends on ovpc_pkg for the geometry and coordinate types and the region-code helpers.
module ovpc_walker #(
   parameter int TREE_DEPTH = ovpc_pkg::TREE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          follow,
   input  ovpc_pkg::coord_type           point,
   input  logic [3*TREE_DEPTH-1:0]       select,
   input  ovpc_pkg::geometry_type        geometry,
   output logic                          done,
   output logic [3*TREE_DEPTH-1:0]       path,
   output ovpc_pkg::coord_type           center
);
   import ovpc_pkg::*;

   localparam int LEAF_BITS  = 3 * TREE_DEPTH;
   localparam int FRAC_EXTRA = TREE_DEPTH + 1;
   localparam int CW         = TREE_DEPTH + 19;
   localparam int SW         = TREE_DEPTH + 15;
   localparam int LVL_W      = $clog2(TREE_DEPTH + 1);
   localparam logic [LVL_W-1:0]     LAST_LEVEL = LVL_W'(TREE_DEPTH - 1);
   localparam logic signed [CW-1:0] HALF       = CW'(1) << (FRAC_EXTRA - 1);
   localparam logic signed [CW-1:0] Q_MAX      = CW'(32767);
   localparam logic signed [CW-1:0] Q_MIN      = -CW'(32768);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [LVL_W-1:0]      lvl_ff;
   logic                  follow_ff;
   logic signed [CW-1:0]  p_ff [3];
   logic signed [CW-1:0]  c_ff [3];
   logic [SW-1:0]         s_ff [3];
   logic [LEAF_BITS-1:0]  idx_ff;
   logic [LEAF_BITS-1:0]  path_ff;

   logic signed [CW-1:0]  diff [3];
   logic signed [CW-1:0]  c_in [3];
   logic signed [CW-1:0]  step [3];
   logic signed [CW-1:0]  rsum [3];
   logic signed [CW-1:0]  rq   [3];
   logic signed [COORD_W-1:0] rsat [3];
   logic [2:0]            code;
   logic [2:0]            neg;
   logic                  last;

   // Centre and point coordinates are kept exactly, FRAC_EXTRA bits below Q8.8.
   function automatic logic signed [CW-1:0] widen(input logic signed [COORD_W-1:0] v);
      logic signed [CW-1:0] w;
      w = CW'(v);
      widen = w <<< FRAC_EXTRA;
   endfunction

   assign last = busy_ff && (lvl_ff == LAST_LEVEL);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = p_ff[a] - c_ff[a];
      end
      code = follow_ff ? region_code(diff[0][CW-1], diff[1][CW-1], diff[2][CW-1])
                       : idx_ff[LEAF_BITS-1 -: 3];
      neg = region_neg(code);
      for (int a = 0; a < 3; a++) begin
         step[a] = signed'(CW'(s_ff[a]));
         c_in[a] = neg[a] ? (c_ff[a] - step[a]) : (c_ff[a] + step[a]);
         // Round to nearest, ties up, then clamp to the Q8.8 range.
         rsum[a] = c_ff[a] + HALF;
         rq[a]   = rsum[a] >>> FRAC_EXTRA;
         if (rq[a] > Q_MAX) begin
            rsat[a] = 16'sh7fff;
         end else if (rq[a] < Q_MIN) begin
            rsat[a] = -16'sh8000;
         end else begin
            rsat[a] = rq[a][COORD_W-1:0];
         end
      end
   end

   always_comb begin
      done_in = last;
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         p_ff[0]   <= widen(point.x);
         p_ff[1]   <= widen(point.y);
         p_ff[2]   <= widen(point.z);
         c_ff[0]   <= widen(geometry.center_x);
         c_ff[1]   <= widen(geometry.center_y);
         c_ff[2]   <= widen(geometry.center_z);
         s_ff[0]   <= SW'(geometry.extent_x) << (TREE_DEPTH - 1);
         s_ff[1]   <= SW'(geometry.extent_y) << (TREE_DEPTH - 1);
         s_ff[2]   <= SW'(geometry.extent_z) << (TREE_DEPTH - 1);
         idx_ff    <= select;
         path_ff   <= '0;
         lvl_ff    <= '0;
         follow_ff <= follow;
      end else if (busy_ff) begin
         for (int a = 0; a < 3; a++) begin
            c_ff[a] <= c_in[a];
            s_ff[a] <= s_ff[a] >> 1;
         end
         idx_ff  <= idx_ff << 3;
         path_ff <= (path_ff << 3) | LEAF_BITS'(code);
         lvl_ff  <= lvl_ff + LVL_W'(1);
      end
   end

   assign done     = done_ff;
   assign path     = path_ff;
   assign center.x = rsat[0];
   assign center.y = rsat[1];
   assign center.z = rsat[2];

endmodule

// ===== rtl/core/ovpc_leaf_store.sv =====
// Leaf count memory of the voxel point counter: one read and one write port,
// registered read data, and a clearing pass over every entry after reset.
// Depends on ovpc_pkg only by convention; no package items are needed.
module ovpc_leaf_store #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic              clearing
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [DATA_W-1:0] mem_wd;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
      mem_we = clr_busy_ff || wr_en;
      mem_wa = clr_busy_ff ? clr_addr_ff : wr_addr;
      mem_wd = clr_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

// ===== rtl/core/octree_voxel_point_counter.sv =====
// Top level of the octree voxel point counter: register file, item sequencer,
// totals and result register. Depends on ovpc_pkg, ovpc_walker, ovpc_leaf_store
// and octree_voxel_point_counter_assert.svh.
//
//   Port group  Dir  Role                         Payload
//   req_*       in   points to add, leaf reads    tdata 64 b, tuser 1 b (kind)
//   rsp_*       out  one result per item          tdata 112 b
//   csr_*       in   register access              pwdata/prdata 32 b
//
// An item passes from acceptance through one walker step per tree level, then the count
// memory read and the update, which waits for a free result register to load the result.
// After reset all 2^(3*TREE_DEPTH) entries of the count memory (4096 by default) are swept clear;
// no item is accepted until then, while register writes are taken as usual.
// A result waiting on rsp_tready does not block acceptance of the next item; only the
// update of that next item waits for the result register to empty.
module octree_voxel_point_counter #(
   parameter int TREE_DEPTH = ovpc_pkg::TREE_DEPTH_DEFAULT,
   parameter int COUNT_BITS = ovpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] point_x, [31:16] point_y, [47:32] point_z, [59:48] leaf_select, [63:60] zero
   input  logic [63:0]                         req_tdata,
   // [0] kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] leaf_index, [27:12] leaf_count, [43:28] total_count, [59:44] max_count,
   // [60] meets_filter, [76:61] leaf_center_x, [92:77] leaf_center_y,
   // [108:93] leaf_center_z, [111:109] zero
   output logic [111:0]                        rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ovpc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ovpc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ovpc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ovpc_pkg::*;

   `include "octree_voxel_point_counter_assert.svh"

   localparam int LEAF_BITS = 3 * TREE_DEPTH;
   localparam int CMP_W     = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
   localparam int IDX_W     = (LEAF_BITS > INDEX_W) ? LEAF_BITS : INDEX_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   // Configuration registers.
   geometry_type      geom_ff;
   logic [REG_W-1:0]  min_leaf_ff;
   logic              csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   // Sequencer and totals.
   logic [1:0]            state_ff, state_in;
   logic                  kind_ff;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] max_ff, max_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [111:0]          rsp_data_ff;

   logic                  accept;
   logic                  slot_free;
   logic                  fire;
   logic                  is_add;
   coord_type             point;
   logic [IDX_W-1:0]      select_wide;
   logic                  walk_done;
   logic [LEAF_BITS-1:0]  walk_path;
   coord_type             walk_center;
   logic [COUNT_BITS-1:0] store_rd_data;
   logic                  store_wr_en;
   logic                  store_clearing;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [CMP_W-1:0]      new_cnt_wide;
   logic [CMP_W-1:0]      total_wide;
   logic [CMP_W-1:0]      max_wide;
   logic [IDX_W-1:0]      leaf_wide;
   logic                  meets;
   logic [111:0]          rsp_data_in;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.center_x <= '0;
         geom_ff.center_y <= '0;
         geom_ff.center_z <= '0;
         geom_ff.extent_x <= EXTENT_RESET;
         geom_ff.extent_y <= EXTENT_RESET;
         geom_ff.extent_z <= EXTENT_RESET;
         min_leaf_ff      <= MIN_LEAF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CENTER_X: geom_ff.center_x <= csr_pwdata[REG_W-1:0];
            REG_CENTER_Y: geom_ff.center_y <= csr_pwdata[REG_W-1:0];
            REG_CENTER_Z: geom_ff.center_z <= csr_pwdata[REG_W-1:0];
            REG_EXTENT_X: geom_ff.extent_x <= csr_pwdata[REG_W-1:0];
            REG_EXTENT_Y: geom_ff.extent_y <= csr_pwdata[REG_W-1:0];
            REG_EXTENT_Z: geom_ff.extent_z <= csr_pwdata[REG_W-1:0];
            REG_MIN_LEAF: min_leaf_ff      <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CENTER_X: csr_prdata = CSR_DATA_W'(unsigned'(geom_ff.center_x));
         REG_CENTER_Y: csr_prdata = CSR_DATA_W'(unsigned'(geom_ff.center_y));
         REG_CENTER_Z: csr_prdata = CSR_DATA_W'(unsigned'(geom_ff.center_z));
         REG_EXTENT_X: csr_prdata = CSR_DATA_W'(geom_ff.extent_x);
         REG_EXTENT_Y: csr_prdata = CSR_DATA_W'(geom_ff.extent_y);
         REG_EXTENT_Z: csr_prdata = CSR_DATA_W'(geom_ff.extent_z);
         REG_MIN_LEAF: csr_prdata = CSR_DATA_W'(min_leaf_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- tree walk
   assign req_tready  = (state_ff == ST_IDLE) && !store_clearing;
   assign accept      = req_tvalid && req_tready;
   assign point.x     = req_tdata[15:0];
   assign point.y     = req_tdata[31:16];
   assign point.z     = req_tdata[47:32];
   assign select_wide = IDX_W'(req_tdata[59:48]);

   ovpc_walker #(
      .TREE_DEPTH (TREE_DEPTH)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .follow   (req_tuser == KIND_ADD),
      .point    (point),
      .select   (select_wide[LEAF_BITS-1:0]),
      .geometry (geom_ff),
      .done     (walk_done),
      .path     (walk_path),
      .center   (walk_center)
   );

   // ---------------------------------------------------------------- count store
   // The read is issued as the walk finishes; the write-back happens in the
   // update cycle, before the next item can issue its read.
   ovpc_leaf_store #(
      .ADDR_W (LEAF_BITS),
      .DATA_W (COUNT_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (walk_done),
      .rd_addr  (walk_path),
      .rd_data  (store_rd_data),
      .wr_en    (store_wr_en),
      .wr_addr  (walk_path),
      .wr_data  (cnt_inc),
      .clearing (store_clearing)
   );

   // ---------------------------------------------------------------- update
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign fire        = (state_ff == ST_UPDATE) && slot_free;
   assign is_add      = (kind_ff == KIND_ADD);
   assign store_wr_en = fire && is_add;

   always_comb begin
      cnt_inc  = (store_rd_data == COUNT_MAX) ? store_rd_data
                                              : store_rd_data + COUNT_BITS'(1);
      new_cnt  = is_add ? cnt_inc : store_rd_data;
      total_in = total_ff;
      max_in   = max_ff;
      if (store_wr_en) begin
         if (total_ff != COUNT_MAX) begin
            total_in = total_ff + COUNT_BITS'(1);
         end
         if (cnt_inc > max_ff) begin
            max_in = cnt_inc;
         end
      end
      new_cnt_wide = CMP_W'(new_cnt);
      total_wide   = CMP_W'(total_in);
      max_wide     = CMP_W'(max_in);
      leaf_wide    = IDX_W'(walk_path);
      meets        = new_cnt_wide >= CMP_W'(min_leaf_ff);
      rsp_data_in  = {3'b000,
                      walk_center.z, walk_center.y, walk_center.x,
                      meets,
                      max_wide[OCOUNT_W-1:0],
                      total_wide[OCOUNT_W-1:0],
                      new_cnt_wide[OCOUNT_W-1:0],
                      leaf_wide[INDEX_W-1:0]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_tuser;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `OVPC_ASSERT_IMPLY(a_no_item_while_clearing, clock, reset,
      accept, !store_clearing, "item accepted during the clearing sweep")
   `OVPC_ASSERT_IMPLY(a_walk_done_in_walk, clock, reset,
      walk_done, state_ff == ST_WALK, "walker finished outside the walk state")
   `OVPC_ASSERT_IMPLY(a_max_within_total, clock, reset,
      1'b1, max_ff <= total_ff, "largest leaf count exceeds the total")
   `OVPC_ASSERT_NEXT(a_update_loads_result, clock, reset,
      fire, rsp_valid_ff && (state_ff == ST_IDLE), "update did not load the result")

endmodule

// ===== tb/octree_voxel_point_counter_tb.sv =====
// Self-checking testbench for octree_voxel_point_counter: directed and random point adds and
// leaf reads, each result checked field by field against an octree model kept in the bench.
// Depends on ovpc_pkg and the octree_voxel_point_counter RTL.
module octree_voxel_point_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ovpc_pkg::*;

   localparam int DEPTH = TREE_DEPTH_DEFAULT;
   localparam int LEAF_BITS = 3 * DEPTH;
   localparam int LEAVES = 1 << LEAF_BITS;
   localparam int FRAC_SHIFT = DEPTH + 1;
   localparam int LATENCY = DEPTH + 3;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PILEUP_ADDS = 48;
   localparam logic [OCOUNT_W-1:0] COUNT_FULL = '1;
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic                      kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [SELECT_W-1:0]       leaf_sel;
   } voxel_request_type;

   typedef struct packed {
      logic [2:0]                spare;
      logic signed [COORD_W-1:0] center_z;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_x;
      logic                      meets_filter;
      logic [OCOUNT_W-1:0]       max_count;
      logic [OCOUNT_W-1:0]       total_count;
      logic [OCOUNT_W-1:0]       leaf_count;
      logic [INDEX_W-1:0]        leaf_index;
   } leaf_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Bench copy of the counters and the geometry.
   logic [OCOUNT_W-1:0] leaf_tally [LEAVES];
   logic [OCOUNT_W-1:0] points_added = '0;
   logic [OCOUNT_W-1:0] busiest_leaf = '0;
   logic signed [COORD_W-1:0] root_cx = '0;
   logic signed [COORD_W-1:0] root_cy = '0;
   logic signed [COORD_W-1:0] root_cz = '0;
   logic [REG_W-1:0] root_ex = EXTENT_RESET;
   logic [REG_W-1:0] root_ey = EXTENT_RESET;
   logic [REG_W-1:0] root_ez = EXTENT_RESET;
   logic [REG_W-1:0] min_points = MIN_LEAF_RESET;

   leaf_report_type pending_reports [$];
   logic [INDEX_W-1:0] last_leaf = '0;

   int burst_left = 0;
   int gap_max = 0;
   int stall_request = 0;
   bit receiver_free = 1'b0;
   int items_sent = 0;
   int adds_sent = 0;
   int reads_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int settings_programmed = 0;
   int holdoffs_done = 0;

   octree_voxel_point_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [COORD_W-1:0] round_to_q88(input longint exact);
      longint q;
      // Arithmetic shift floors, so adding half first rounds ties toward +infinity.
      q = (exact + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[COORD_W-1:0];
   endfunction

   // Walks the tree for one item, updates the bench counters on an add and returns the
   // result the block should give.
   function automatic leaf_report_type locate_and_count(input voxel_request_type item);
      longint cell_x, cell_y, cell_z, ext_x, ext_y, ext_z, step, px, py, pz;
      logic below_x, below_y, below_z;
      logic [2:0] code;
      logic [LEAF_BITS-1:0] path;
      leaf_report_type r;
      cell_x = longint'(root_cx) * (1 << FRAC_SHIFT);
      cell_y = longint'(root_cy) * (1 << FRAC_SHIFT);
      cell_z = longint'(root_cz) * (1 << FRAC_SHIFT);
      ext_x = longint'(root_ex);
      ext_y = longint'(root_ey);
      ext_z = longint'(root_ez);
      px = longint'(item.x) * (1 << FRAC_SHIFT);
      py = longint'(item.y) * (1 << FRAC_SHIFT);
      pz = longint'(item.z) * (1 << FRAC_SHIFT);
      path = '0;
      for (int lvl = 0; lvl < DEPTH; lvl++) begin
         step = longint'(1) << (DEPTH - 1 - lvl);
         if (item.kind == KIND_ADD) begin
            below_x = px < cell_x;
            below_y = py < cell_y;
            below_z = pz < cell_z;
            // y picks the upper half of the code table, x the pair, and z the entry,
            // with the z order reversed on the negative x side.
            code = {below_y, below_x, below_x ^ below_z};
         end else begin
            code = item.leaf_sel[3 * (DEPTH - 1 - lvl) +: 3];
         end
         path = (path << 3) | LEAF_BITS'(code);
         cell_x += code[1] ? -(ext_x * step) : ext_x * step;
         cell_y += code[2] ? -(ext_y * step) : ext_y * step;
         cell_z += (code[0] ^ code[1]) ? -(ext_z * step) : ext_z * step;
      end
      if (item.kind == KIND_ADD) begin
         if (leaf_tally[path] != COUNT_FULL) leaf_tally[path] = leaf_tally[path] + OCOUNT_W'(1);
         if (points_added != COUNT_FULL) points_added = points_added + OCOUNT_W'(1);
         if (leaf_tally[path] > busiest_leaf) busiest_leaf = leaf_tally[path];
      end
      r.spare = '0;
      r.leaf_index = path;
      r.leaf_count = leaf_tally[path];
      r.total_count = points_added;
      r.max_count = busiest_leaf;
      r.meets_filter = leaf_tally[path] >= min_points;
      r.center_x = round_to_q88(cell_x);
      r.center_y = round_to_q88(cell_y);
      r.center_z = round_to_q88(cell_z);
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_q88(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // Mostly points inside the root cell or on leaf boundaries, the rest anywhere.
   function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] center, input logic [REG_W-1:0] width);
      int mode, half, v;
      mode = $urandom_range(0, 9);
      half = int'(width) / 2;
      if (mode < 3)
         v = int'($urandom_range(0, 65535)) - 32768;
      else if (mode < 5)
         v = int'(center) + (int'(width) * (int'($urandom_range(0, 16)) - 8)) / 16
             + int'($urandom_range(0, 2)) - 1;
      else
         v = int'(center) + int'($urandom_range(0, 2 * half)) - half;
      return clamp_q88(v);
   endfunction

   function automatic voxel_request_type random_item();
      voxel_request_type it;
      it.kind = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_ADD;
      it.x = pick_coord(root_cx, root_ex);
      it.y = pick_coord(root_cy, root_ey);
      it.z = pick_coord(root_cz, root_ez);
      it.leaf_sel = ($urandom_range(0, 9) < 6) ? last_leaf : SELECT_W'($urandom());
      return it;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < 50)
         $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Offers one item and returns at the clock edge that accepts it.
   task automatic send_item(input voxel_request_type item);
      leaf_report_type r;
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser <= item.kind;
      req_tdata <= {4'b0, item.leaf_sel, item.z, item.y, item.x};
      do @(posedge clock); while (!req_tready);
      r = locate_and_count(item);
      pending_reports.insert(pending_reports.size(), r);
      if (item.kind == KIND_ADD) begin
         last_leaf = r.leaf_index;
         adds_sent++;
      end else begin
         reads_sent++;
      end
      burst_left--;
      items_sent++;
   endtask

   task automatic add_point(input int x, input int y, input int z);
      voxel_request_type it;
      it.kind = KIND_ADD;
      it.x = clamp_q88(x);
      it.y = clamp_q88(y);
      it.z = clamp_q88(z);
      it.leaf_sel = SELECT_W'($urandom());
      send_item(it);
   endtask

   task automatic read_leaf(input logic [SELECT_W-1:0] sel);
      voxel_request_type it;
      it.kind = KIND_READ;
      it.x = COORD_W'($urandom());
      it.y = COORD_W'($urandom());
      it.z = COORD_W'($urandom());
      it.leaf_sel = sel;
      send_item(it);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_item(random_item());
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_reports.size() > 0);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [REG_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {16'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_CENTER_X: root_cx = value;
         REG_CENTER_Y: root_cy = value;
         REG_CENTER_Z: root_cz = value;
         REG_EXTENT_X: root_ex = value;
         REG_EXTENT_Y: root_ey = value;
         REG_EXTENT_Z: root_ez = value;
         REG_MIN_LEAF: min_points = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_geometry(input logic [15:0] cx, input logic [15:0] cy,
                                   input logic [15:0] cz, input logic [15:0] ex,
                                   input logic [15:0] ey, input logic [15:0] ez,
                                   input logic [15:0] threshold);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_EXTENT_X, ex);
      write_reg(REG_EXTENT_Y, ey);
      write_reg(REG_EXTENT_Z, ez);
      write_reg(REG_MIN_LEAF, threshold);
      settings_programmed++;
   endtask

   task automatic test_reset_state();
      gap_max = 3;
      read_leaf('0);
      read_leaf('1);
      read_leaf(12'h5A3);
   endtask

   task automatic test_directed_points();
      logic [2:0] code;
      gap_max = 2;
      add_point(0, 0, 0);                  // exactly on the root center
      add_point(-1, -1, -1);               // one step below it on every axis
      add_point(32767, 32767, 32767);      // far outside the root cell
      add_point(-32768, -32768, -32768);
      add_point(32767, -32768, 0);
      add_point(-32768, 32767, -1);
      // One point in each root octant, three units from the center.
      for (int c = 0; c < 8; c++) begin
         code = c[2:0];
         add_point(code[1] ? -768 : 768, code[2] ? -768 : 768,
                   (code[0] ^ code[1]) ? -768 : 768);
      end
      add_point(256, -256, 512);           // lies on leaf boundaries
      add_point(256, -256, 512);
      read_leaf(last_leaf);
      read_leaf('0);
      read_leaf(12'o6666);
   endtask

   task automatic test_register_settings();
      wait_drained();
      // A write past the last register must not disturb anything.
      write_reg(REG_UNMAPPED, 16'($urandom()));
      read_leaf(last_leaf);
      wait_drained();
      program_geometry(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      gap_max = 0;
      send_random(240);
      wait_drained();
      program_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'd0, 16'd0,
                       16'd0, 16'd2);
      gap_max = 4;
      send_random(240);
      wait_drained();
      program_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom_range(1, 255)), 16'($urandom_range(1, 255)),
                       16'($urandom_range(1, 255)), 16'hFFFF);
      gap_max = 1;
      send_random(240);
      wait_drained();
      program_geometry(-16'sd256, 16'sd512, 16'sd0, 16'hFFFF, 16'd0, 16'd1, 16'd3);
      gap_max = 6;
      send_random(240);
      wait_drained();
      program_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 8)));
      gap_max = 2;
      send_random(240);
   endtask

   task automatic test_receiver_holdoff();
      gap_max = 0;
      stall_request = HOLDOFF_CYCLES;
      send_random(60);
      wait_drained();
   endtask

   task automatic test_drain_pauses();
      for (int n = 0; n < 4; n++) begin
         gap_max = n;
         send_random($urandom_range(10, 40));
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      wait_drained();
      program_geometry(16'($urandom_range(0, 8192) - 4096), 16'($urandom_range(0, 8192) - 4096),
                       16'($urandom_range(0, 8192) - 4096), 16'($urandom_range(1024, 16384)),
                       16'($urandom_range(1024, 16384)), 16'($urandom_range(1024, 16384)),
                       16'($urandom_range(1, 4)));
      for (int n = 0; n < 6; n++) begin
         gap_max = (n % 3) * 3;
         send_random(100);
      end
   endtask

   // Piles points into one leaf back to back, then reads it with a high and a zero threshold.
   task automatic test_single_leaf_pileup();
      voxel_request_type it;
      wait_drained();
      program_geometry(16'd0, 16'd0, 16'd0, EXTENT_RESET, EXTENT_RESET, EXTENT_RESET,
                       16'hFFFF);
      receiver_free = 1'b1;
      gap_max = 0;
      it.kind = KIND_ADD;
      it.x = 16'sd128;
      it.y = 16'sd128;
      it.z = 16'sd128;
      it.leaf_sel = '0;
      repeat (PILEUP_ADDS) send_item(it);
      read_leaf(last_leaf);
      read_leaf('1);
      wait_drained();
      write_reg(REG_MIN_LEAF, 16'd0);
      read_leaf('1);
      read_leaf(last_leaf);
      wait_drained();
      receiver_free = 1'b0;
   endtask

   initial begin : receiver
      int style, style_left, phase;
      logic ready_next;
      style = 0;
      style_left = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (stall_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_request) @(posedge clock);
            stall_request = 0;
            holdoffs_done++;
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 3);
               style_left = $urandom_range(16, 160);
            end
            style_left--;
            phase++;
            case (style)
               0: ready_next = 1'b1;
               1: ready_next = $urandom_range(0, 1);
               2: ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = (phase % 5) != 4;
            endcase
            rsp_tready <= ready_next | receiver_free;
         end
      end
   end

   always @(posedge clock) begin : result_check
      leaf_report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = leaf_report_type'(rsp_tdata);
         if (pending_reports.size() == 0) begin
            report_mismatch("result with no transaction outstanding, leaf_index",
                            got.leaf_index, -1);
         end else begin
            want = pending_reports.pop_front();
            if (got.leaf_index !== want.leaf_index)
               report_mismatch("leaf_index", got.leaf_index, want.leaf_index);
            if (got.leaf_count !== want.leaf_count)
               report_mismatch("leaf_count", got.leaf_count, want.leaf_count);
            if (got.total_count !== want.total_count)
               report_mismatch("total_count", got.total_count, want.total_count);
            if (got.max_count !== want.max_count)
               report_mismatch("max_count", got.max_count, want.max_count);
            if (got.meets_filter !== want.meets_filter)
               report_mismatch("meets_filter", got.meets_filter, want.meets_filter);
            if (got.center_x !== want.center_x)
               report_mismatch("leaf_center_x", got.center_x, want.center_x);
            if (got.center_y !== want.center_y)
               report_mismatch("leaf_center_y", got.center_y, want.center_y);
            if (got.center_z !== want.center_z)
               report_mismatch("leaf_center_z", got.center_z, want.center_z);
            if (got.spare !== want.spare)
               report_mismatch("rsp_tdata pad bits", got.spare, want.spare);
            results_checked++;
         end
      end
   end

   // The limit covers the clearing pass after reset and the long receiver hold-off.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("%t no transaction for %0d cycles, %0d results outstanding", $realtime,
               IDLE_LIMIT, pending_reports.size());
      $display("octree_voxel_point_counter regression: fail");
      $finish;
   end

   initial begin : run
      foreach (leaf_tally[i]) leaf_tally[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_points();
      test_register_settings();
      test_receiver_holdoff();
      test_drain_pauses();
      test_random_traffic();
      test_single_leaf_pileup();
      wait_drained();
      repeat (LATENCY + 8) @(posedge clock);
      $display("Covered %0d items (%0d adds, %0d reads) over %0d register settings,",
               items_sent, adds_sent, reads_sent, settings_programmed);
      $display("%0d results checked, %0d receiver hold-offs, %0d mismatches.",
               results_checked, holdoffs_done, mismatches);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("octree_voxel_point_counter regression: pass");
      else
         $display("octree_voxel_point_counter regression: fail");
      $finish;
   end

endmodule
